[design/ldp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Limb divide package
// Widths, register indexes, opcodes and shared types for the limb divider.
// ----------------------------------------------------------------------------
package ldp_pkg;

  localparam int LimbW     = 32;
  localparam int DoubleW   = 2 * LimbW;
  localparam int NumStages = 6;
  localparam int CfgIdxW   = 2;
  localparam int OccW      = $clog2(NumStages + 1);

  typedef logic [LimbW-1:0]   limb_t;
  typedef logic [DoubleW-1:0] dlimb_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SINGLE_DIVISOR    = 2'd0,
    REG_PAIR_DIVISOR_HIGH = 2'd1,
    REG_PAIR_DIVISOR_LOW  = 2'd2,
    REG_RECIPROCAL        = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_TWO_BY_ONE   = 1'b0,
    OP_THREE_BY_TWO = 1'b1
  } opcode_t;

  localparam limb_t SingleDivisorReset   = 32'h8000_0000;
  localparam limb_t PairDivisorHighReset = 32'h8000_0000;
  localparam limb_t PairDivisorLowReset  = 32'h0000_0000;
  localparam limb_t ReciprocalReset      = 32'hFFFF_FFFF;

  typedef struct packed {
    limb_t single_divisor;
    limb_t pair_divisor_high;
    limb_t pair_divisor_low;
    limb_t reciprocal;
  } cfg_regs_t;

  typedef struct packed {
    logic [NumStages-1:0] stage_valid;
  } core_status_t;

endpackage
`default_nettype wire

[design/ldp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Limb divide channels
// Dividend, result and configuration channels with valid and ready.
// ----------------------------------------------------------------------------
interface ldp_dividend_if import ldp_pkg::*; ();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  limb_t   word_top;
  limb_t   word_mid;
  limb_t   word_bottom;

  modport source(output valid, output opcode, output word_top, output word_mid,
                 output word_bottom, input ready);
  modport sink(input valid, input opcode, input word_top, input word_mid,
               input word_bottom, output ready);
endinterface

interface ldp_result_if import ldp_pkg::*; ();
  logic  valid;
  logic  ready;
  limb_t quotient;
  limb_t remainder_high;
  limb_t remainder_low;

  modport source(output valid, output quotient, output remainder_high,
                 output remainder_low, input ready);
  modport sink(input valid, input quotient, input remainder_high,
               input remainder_low, output ready);
endinterface

interface ldp_cfg_if import ldp_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_reg_t index;
  limb_t    data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[design/ldp_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Limb divide pipeline
// Six-stage reciprocal divide datapath with per-stage valid bits and stall.
// ----------------------------------------------------------------------------
module ldp_pipe import ldp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_regs_t             regs,
  ldp_dividend_if.sink          dividend,
  ldp_result_if.source          result,
  output core_status_t          status
);

  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] vld_next;
  logic [NumStages-1:0] en;

  dlimb_t pair_divisor;
  assign pair_divisor = {regs.pair_divisor_high, regs.pair_divisor_low};

  // Stage 1: reciprocal product
  opcode_t s1_op;
  limb_t   s1_hi, s1_lo, s1_bot;
  dlimb_t  s1_prod;
  // Stage 2: quotient estimate
  opcode_t s2_op;
  limb_t   s2_qh, s2_ql, s2_lo, s2_bot;
  // Stage 3: back products
  opcode_t s3_op;
  limb_t   s3_qh, s3_ql, s3_lo, s3_bot, s3_pa;
  dlimb_t  s3_pb;
  // Stage 4: raw remainder
  opcode_t s4_op;
  limb_t   s4_q, s4_ql;
  dlimb_t  s4_r;
  // Stage 5: first correction
  opcode_t s5_op;
  limb_t   s5_q;
  dlimb_t  s5_r;
  // Stage 6: second correction, output register
  limb_t   s6_q;
  dlimb_t  s6_r;

  limb_t  in_hi, in_lo, s2_lo_sel, s4_rh;
  dlimb_t s2_sum, s4_r_next, s5_div, s5_sum, s6_div, s6_diff;
  logic   s5_fix, s6_fix;

  always_comb begin
    en[NumStages-1] = !vld[NumStages-1] || result.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
    for (int k = 0; k < NumStages; k++) begin
      if (en[k]) begin
        vld_next[k] = (k == 0) ? dividend.valid : vld[(k == 0) ? 0 : k - 1];
      end else begin
        vld_next[k] = vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign in_hi = (dividend.opcode == OP_THREE_BY_TWO) ? dividend.word_top : dividend.word_mid;
  assign in_lo = (dividend.opcode == OP_THREE_BY_TWO) ? dividend.word_mid
                                                     : dividend.word_bottom;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_op   <= dividend.opcode;
      s1_hi   <= in_hi;
      s1_lo   <= in_lo;
      s1_bot  <= dividend.word_bottom;
      s1_prod <= DoubleW'(in_hi) * DoubleW'(regs.reciprocal);
    end
  end

  assign s2_sum    = s1_prod + {s1_hi, s1_lo};
  assign s2_lo_sel = s2_sum[DoubleW-1:LimbW] + ((s1_op == OP_TWO_BY_ONE) ? limb_t'(1) : '0);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_op  <= s1_op;
      s2_qh  <= s2_lo_sel;
      s2_ql  <= s2_sum[LimbW-1:0];
      s2_lo  <= s1_lo;
      s2_bot <= s1_bot;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_op  <= s2_op;
      s3_qh  <= s2_qh;
      s3_ql  <= s2_ql;
      s3_lo  <= s2_lo;
      s3_bot <= s2_bot;
      s3_pa  <= s2_qh * ((s2_op == OP_THREE_BY_TWO) ? regs.pair_divisor_high
                                                     : regs.single_divisor);
      s3_pb  <= DoubleW'(s2_qh) * DoubleW'(regs.pair_divisor_low);
    end
  end

  // The low dividend limb minus the first back product is the whole
  // remainder for two-by-one and the high remainder limb for three-by-two.
  assign s4_rh = s3_lo - s3_pa;

  always_comb begin
    if (s3_op == OP_THREE_BY_TWO) begin
      s4_r_next = {s4_rh, s3_bot} - s3_pb - pair_divisor;
    end else begin
      s4_r_next = {{LimbW{1'b0}}, s4_rh};
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_op <= s3_op;
      s4_ql <= s3_ql;
      s4_r  <= s4_r_next;
      s4_q  <= s3_qh + ((s3_op == OP_THREE_BY_TWO) ? limb_t'(1) : '0);
    end
  end

  always_comb begin
    if (s4_op == OP_THREE_BY_TWO) begin
      s5_div = pair_divisor;
      s5_fix = s4_r[DoubleW-1:LimbW] >= s4_ql;
      s5_sum = s4_r + s5_div;
    end else begin
      s5_div = {{LimbW{1'b0}}, regs.single_divisor};
      s5_fix = s4_r[LimbW-1:0] > s4_ql;
      s5_sum = {{LimbW{1'b0}}, s4_r[LimbW-1:0] + regs.single_divisor};
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_op <= s4_op;
      s5_q  <= s5_fix ? s4_q - limb_t'(1) : s4_q;
      s5_r  <= s5_fix ? s5_sum : s4_r;
    end
  end

  always_comb begin
    if (s5_op == OP_THREE_BY_TWO) begin
      s6_div  = pair_divisor;
      s6_diff = s5_r - s6_div;
    end else begin
      s6_div  = {{LimbW{1'b0}}, regs.single_divisor};
      s6_diff = {{LimbW{1'b0}}, s5_r[LimbW-1:0] - regs.single_divisor};
    end
    s6_fix = s5_r >= s6_div;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_q <= s6_fix ? s5_q + limb_t'(1) : s5_q;
      s6_r <= s6_fix ? s6_diff : s5_r;
    end
  end

  assign dividend.ready        = en[0];
  assign result.valid          = vld[NumStages-1];
  assign result.quotient       = s6_q;
  assign result.remainder_high = s6_r[DoubleW-1:LimbW];
  assign result.remainder_low  = s6_r[LimbW-1:0];
  assign status.stage_valid    = vld;

endmodule
`default_nettype wire

[design/limb_divide_preinverted_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Limb divide by precomputed reciprocal
// Two-by-one and three-by-two limb division with configuration registers.
// ----------------------------------------------------------------------------
// The block takes one dividend word every clock unless the result is stalled
// and returns each result through a six-stage pipeline in which the reciprocal
// product and the back products each have a multiplier stage of their own.
// A stalled result holds the pipeline without losing or repeating a word.
// Divisors and the reciprocal are written through the configuration channel,
// which is always ready, and are expected to change only while the block
// holds no word.
module limb_divide_preinverted_top import ldp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ldp_cfg_if.sink      cfg,
  ldp_dividend_if.sink dividend,
  ldp_result_if.source result
);

  cfg_regs_t        regs;
  core_status_t     status;
  logic [OccW-1:0]  occ;
  logic             in_acc;
  logic             out_acc;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.single_divisor    <= SingleDivisorReset;
      regs.pair_divisor_high <= PairDivisorHighReset;
      regs.pair_divisor_low  <= PairDivisorLowReset;
      regs.reciprocal        <= ReciprocalReset;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SINGLE_DIVISOR:    regs.single_divisor    <= cfg.data;
        REG_PAIR_DIVISOR_HIGH: regs.pair_divisor_high <= cfg.data;
        REG_PAIR_DIVISOR_LOW:  regs.pair_divisor_low  <= cfg.data;
        REG_RECIPROCAL:        regs.reciprocal        <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  ldp_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .regs     (regs),
    .dividend (dividend),
    .result   (result),
    .status   (status)
  );

  assign in_acc  = dividend.valid && dividend.ready;
  assign out_acc = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OccW'(in_acc) - OccW'(out_acc);
    end
  end

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    $countones(status.stage_valid) == int'(occ))
    else $error("Pipeline valid bits disagree with words in flight.");

  a_no_stall_ready: assert property (@(posedge clk) disable iff (rst)
    result.ready |-> dividend.ready)
    else $error("Input stalled although the output is not stalled.");

  a_entry: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> status.stage_valid[0])
    else $error("Accepted word did not enter the first stage.");

endmodule
`default_nettype wire

[sim/limb_divide_result_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limb divide result checker
// Watches the configuration, dividend and result channels, keeps its own copy
// of the divisor and reciprocal registers, works out the quotient and
// remainder of every accepted dividend word and compares each result word
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module limb_divide_result_check import ldp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  ldp_cfg_if      cfg,
  ldp_dividend_if dividend,
  ldp_result_if   result,
  output int      fails,
  output int      pending
);

  localparam int ReportLimit = 10;

  typedef struct packed {
    limb_t quotient;
    limb_t remainder_high;
    limb_t remainder_low;
  } division_t;

  limb_t     single_div;
  limb_t     pair_high;
  limb_t     pair_low;
  limb_t     recip;
  division_t awaited_divisions[$];

  function automatic division_t divide_item(opcode_t op, limb_t top, limb_t mid, limb_t bot);
    dlimb_t    prod;
    dlimb_t    pair;
    dlimb_t    rem;
    limb_t     qh;
    limb_t     ql;
    limb_t     rh;
    limb_t     rs;
    division_t res;
    if (op == OP_TWO_BY_ONE) begin
      prod = dlimb_t'(mid) * dlimb_t'(recip) + {mid, bot};
      qh = prod[DoubleW-1:LimbW] + 32'd1;
      ql = prod[LimbW-1:0];
      rs = bot - qh * single_div;
      if (rs > ql) begin
        qh = qh - 32'd1;
        rs = rs + single_div;
      end
      if (rs >= single_div) begin
        qh = qh + 32'd1;
        rs = rs - single_div;
      end
      res = '{quotient: qh, remainder_high: '0, remainder_low: rs};
    end else begin
      pair = {pair_high, pair_low};
      prod = dlimb_t'(top) * dlimb_t'(recip) + {top, mid};
      qh = prod[DoubleW-1:LimbW];
      ql = prod[LimbW-1:0];
      rh = mid - qh * pair_high;
      rem = {rh, bot} - dlimb_t'(pair_low) * dlimb_t'(qh) - pair;
      qh = qh + 32'd1;
      if (rem[DoubleW-1:LimbW] >= ql) begin
        qh = qh - 32'd1;
        rem = rem + pair;
      end
      if (rem >= pair) begin
        qh = qh + 32'd1;
        rem = rem - pair;
      end
      res = '{quotient: qh, remainder_high: rem[DoubleW-1:LimbW],
              remainder_low: rem[LimbW-1:0]};
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    division_t got;
    division_t want;
    if (rst) begin
      single_div = SingleDivisorReset;
      pair_high  = PairDivisorHighReset;
      pair_low   = PairDivisorLowReset;
      recip      = ReciprocalReset;
      awaited_divisions.delete();
      fails = 0;
    end else begin
      if (result.valid && result.ready) begin
        got = '{quotient: result.quotient, remainder_high: result.remainder_high,
                remainder_low: result.remainder_low};
        if (awaited_divisions.size() == 0) begin
          fails++;
          if (fails <= ReportLimit) begin
            $display("unexpected result word: q=%h rh=%h rl=%h",
                     got.quotient, got.remainder_high, got.remainder_low);
          end
        end else begin
          want = awaited_divisions.pop_front();
          if (got.quotient !== want.quotient || got.remainder_high !== want.remainder_high ||
              got.remainder_low !== want.remainder_low) begin
            fails++;
            if (fails <= ReportLimit) begin
              $display("result mismatch: expected q=%h rh=%h rl=%h, got q=%h rh=%h rl=%h",
                       want.quotient, want.remainder_high, want.remainder_low,
                       got.quotient, got.remainder_high, got.remainder_low);
            end
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SINGLE_DIVISOR:    single_div = cfg.data;
          REG_PAIR_DIVISOR_HIGH: pair_high = cfg.data;
          REG_PAIR_DIVISOR_LOW:  pair_low = cfg.data;
          REG_RECIPROCAL:        recip = cfg.data;
          default: ;
        endcase
      end
      if (dividend.valid && dividend.ready) begin
        awaited_divisions.push_back(divide_item(dividend.opcode, dividend.word_top,
                                                dividend.word_mid, dividend.word_bottom));
      end
    end
    pending = awaited_divisions.size();
  end

endmodule

[sim/limb_divide_preinverted_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limb divide testbench
// Drives the limb divider with directed dividends at the extremes of the
// divisors, then with phases of random dividends under changing divisor and
// reciprocal settings, with random gaps on both sides, a long result stall
// and a drain pause. The checker beside the block predicts every result word.
// ----------------------------------------------------------------------------
module limb_divide_preinverted_top_test;
  import ldp_pkg::*;

  localparam int PhaseCount    = 10;
  localparam int PhaseItems    = 130;
  localparam int HoldOffCycles = 80;
  localparam int IdleLimit     = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails;
  int   pending;
  bit   tx_steady = 1'b0;
  bit   rx_steady = 1'b0;
  bit   hold_off_req = 1'b0;

  ldp_cfg_if      cfg_ch ();
  ldp_dividend_if div_ch ();
  ldp_result_if   res_ch ();

  limb_divide_preinverted_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_ch),
    .dividend (div_ch),
    .result   (res_ch)
  );

  limb_divide_result_check u_check (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_ch),
    .dividend (div_ch),
    .result   (res_ch),
    .fails    (fails),
    .pending  (pending)
  );

  always #5 clk = ~clk;

  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic limb_t reciprocal_of_limb(limb_t d);
    logic [127:0] q;
    q = {64'd0, {DoubleW{1'b1}}} / {96'd0, d};
    return q[LimbW-1:0];
  endfunction

  function automatic limb_t reciprocal_of_pair(dlimb_t dd);
    logic [127:0] q;
    q = {32'd0, {96{1'b1}}} / {64'd0, dd};
    return q[LimbW-1:0];
  endfunction

  task automatic send_dividend(opcode_t op, limb_t top, limb_t mid, limb_t bot);
    int unsigned gap;
    gap = tx_steady ? 0 : idle_length();
    @(negedge clk);
    if (gap != 0) begin
      div_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    div_ch.opcode      = op;
    div_ch.word_top    = top;
    div_ch.word_mid    = mid;
    div_ch.word_bottom = bot;
    div_ch.valid       = 1'b1;
    do @(posedge clk); while (!div_ch.ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    div_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, limb_t val);
    @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_divisors(limb_t d, limb_t dh, limb_t dl, limb_t rc);
    write_reg(REG_SINGLE_DIVISOR, d);
    write_reg(REG_PAIR_DIVISOR_HIGH, dh);
    write_reg(REG_PAIR_DIVISOR_LOW, dl);
    write_reg(REG_RECIPROCAL, rc);
  endtask

  initial begin : receiver
    int unsigned n;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        res_ch.ready = 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (rx_steady || $urandom_range(0, 99) < 60) begin
        res_ch.ready = 1'b1;
      end else begin
        res_ch.ready = 1'b0;
        n = idle_length();
        repeat (n) @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst == 1'b0);
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if ((div_ch.valid && div_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    limb_t       d;
    limb_t       dh;
    limb_t       dl;
    limb_t       rc;
    limb_t       top;
    limb_t       mid;
    limb_t       bot;
    dlimb_t      dd;
    dlimb_t      x;
    opcode_t     op;
    int unsigned roll;
    div_ch.valid       = 1'b0;
    div_ch.opcode      = OP_TWO_BY_ONE;
    div_ch.word_top    = '0;
    div_ch.word_mid    = '0;
    div_ch.word_bottom = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_SINGLE_DIVISOR;
    cfg_ch.data        = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // The reset reciprocal suits both divisors at their reset values.
    send_dividend(OP_TWO_BY_ONE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_dividend(OP_TWO_BY_ONE, 32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_dividend(OP_TWO_BY_ONE, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    send_dividend(OP_TWO_BY_ONE, 32'h5555_5555, 32'h0000_0001, 32'hAAAA_AAAA);
    send_dividend(OP_THREE_BY_TWO, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_dividend(OP_THREE_BY_TWO, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_dividend(OP_THREE_BY_TWO, 32'h4000_0000, 32'h1234_5678, 32'h9ABC_DEF0);
    // The top part of these dividends is not below the divisor.
    send_dividend(OP_TWO_BY_ONE, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_dividend(OP_THREE_BY_TWO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    drain_results();

    set_divisors(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, reciprocal_of_limb(32'hFFFF_FFFF));
    send_dividend(OP_TWO_BY_ONE, 32'h0000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_dividend(OP_TWO_BY_ONE, 32'hAAAA_AAAA, 32'h0000_0000, 32'h0000_0000);
    send_dividend(OP_TWO_BY_ONE, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001);
    drain_results();
    write_reg(REG_RECIPROCAL, reciprocal_of_pair({32'hFFFF_FFFF, 32'hFFFF_FFFF}));
    send_dividend(OP_THREE_BY_TWO, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_dividend(OP_THREE_BY_TWO, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_dividend(OP_THREE_BY_TWO, 32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0000);
    drain_results();
    write_reg(REG_PAIR_DIVISOR_HIGH, 32'h8000_0000);
    write_reg(REG_RECIPROCAL, reciprocal_of_pair({32'h8000_0000, 32'hFFFF_FFFF}));
    send_dividend(OP_THREE_BY_TWO, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_dividend(OP_THREE_BY_TWO, 32'h0000_0001, 32'h0000_0000, 32'h8000_0000);

    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      d  = (p == 0) ? 32'h8000_0000 : (p == 1) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
      dh = (p == 1) ? 32'hFFFF_FFFF : (p == 2) ? 32'h8000_0000 : ($urandom | 32'h8000_0000);
      dl = (p == 2) ? 32'h0000_0000 : (p == 3) ? 32'hFFFF_FFFF : $urandom;
      dd = {dh, dl};
      if (p == PhaseCount - 1) begin
        rc = $urandom;
      end else if (p % 2 == 0) begin
        rc = reciprocal_of_limb(d);
      end else begin
        rc = reciprocal_of_pair(dd);
      end
      set_divisors(d, dh, dl, rc);
      tx_steady = (p == 4) || (p == 6);
      rx_steady = (p == 6);
      if (p == 4) begin
        hold_off_req = 1'b1;
      end
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 5 && i == PhaseItems / 2) begin
          drain_results();
        end
        roll = $urandom_range(0, 99);
        top  = $urandom;
        mid  = $urandom;
        bot  = $urandom;
        if (roll < 85) begin
          op = (p % 2 == 0) ? OP_TWO_BY_ONE : OP_THREE_BY_TWO;
          if (op == OP_TWO_BY_ONE) begin
            mid = (roll < 4) ? d - 32'd1 : $urandom_range(0, d - 32'd1);
          end else begin
            x = (roll < 4) ? dd - 64'd1 : {$urandom, $urandom} % dd;
            top = x[DoubleW-1:LimbW];
            mid = x[LimbW-1:0];
          end
        end else begin
          op = opcode_t'($urandom_range(0, 1));
        end
        send_dividend(op, top, mid, bot);
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
    end

    drain_results();
    repeat (2 * NumStages) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/ldp_pkg.sv
design/ldp_if.sv
design/ldp_pipe.sv
design/limb_divide_preinverted_top.sv
sim/limb_divide_result_check.sv
sim/limb_divide_preinverted_top_test.sv
